FILE: rtl/core/dcc_pkg.sv
// Constants shared by the day-count to civil-date pipeline.
// No dependencies.
package dcc_pkg;

  localparam int DayW   = 24;
  localparam int YearW  = 16;
  localparam int MonthW = 4;
  localparam int DomW   = 5;

  // x = 4*shifted + 3 - 146097*14470, always in [3813, 67112673]
  localparam int XW = 27;
  localparam logic [27:0] XOffset = 28'd33558245;

  // Division by 146097: reciprocal estimate, then one correction step
  localparam logic [17:0] EraDiv    = 18'd146097;
  localparam logic [17:0] EraRecip  = 18'd235184;   // floor(2^35 / 146097)
  localparam int          EraShift  = 35;
  localparam int          QW        = 9;            // quotient offset, at most 459
  localparam int          RW        = 19;           // remainder before correction
  localparam int          DocW      = 16;           // day of century, at most 36524

  localparam logic [21:0] CenturyMul = 22'd2939745;
  localparam int          YocW       = 7;
  localparam logic [10:0] DaysPer4Y  = 11'd1461;
  localparam int          DoyW       = 9;

  localparam logic [11:0] MonthMul  = 12'd2141;
  localparam logic [19:0] MonthAdd  = 20'd197913;
  localparam logic [15:0] DayRecip  = 16'd62690;    // ceil(2^27 / 2141)
  localparam int          DayShift  = 27;
  localparam logic [8:0]  MarchDays = 9'd306;
  localparam logic [3:0]  Months    = 4'd12;

  // year = 100*q + yoc - 21000, plus one for January and February
  localparam logic [16:0] YearBias  = 17'd21000;

endpackage

FILE: rtl/core/day_count_to_civil_date.sv
// Day count (days since 1970-01-01) to proleptic Gregorian year/month/day.
// One beat per cycle sustained while the output is not stalled.
// Eight register stages share one advance enable; the last stage is the output
// register, so a stalled output freezes every stage and drops s_tready.
// Reset (rst, synchronous) clears only the valid bits; data registers are free.
// Depends on dcc_pkg and dcc_era_div.
module day_count_to_civil_date (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [23:0] day_number (signed)
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [15:0] year (signed), [19:16] month,
                                 // [24:20] day_of_month, [31:25] zero
);

  // Whole pipe moves when the output slot is empty or being taken.
  // No beat is taken while reset is held.
  logic en;
  assign en       = m_tready | ~m_tvalid;
  assign s_tready = en & ~rst;

  // Stages 1-4: x = 4*days + 3 - base, split into q = x / 146097 and
  // the day of the century.
  logic                     v4;
  logic [dcc_pkg::QW-1:0]   q4;
  logic [dcc_pkg::DocW-1:0] doc4;

  dcc_era_div u_era_div (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (s_tvalid),
    .day_number (s_tdata),
    .out_valid  (v4),
    .era_q      (q4),
    .doc        (doc4)
  );

  // Stage 5: year of century from the high word of 2939745*(4*doc+3)
  // Stage 6: day of the March-based year, and the year before the roll
  // Stage 7: month/day linear map 2141*doy + 197913
  // Stage 8: day = low16 / 2141 by reciprocal; Jan/Feb roll into next year
  logic [3:0] vld;   // stages 5..8

  logic [dcc_pkg::QW-1:0]     q5;
  logic [dcc_pkg::DocW-1:0]   doc5;
  logic [dcc_pkg::YocW-1:0]   yoc5;
  logic [dcc_pkg::DoyW-1:0]   doy6;
  logic [16:0]                yb6;
  logic [dcc_pkg::MonthW-1:0] mon7;
  logic [15:0]                lo7;
  logic                       mar7;
  logic [dcc_pkg::YearW-1:0]  year7;
  logic [dcc_pkg::YearW-1:0]  year;
  logic [dcc_pkg::MonthW-1:0] month;
  logic [dcc_pkg::DomW-1:0]   day_of_month;

  logic [39:0] cent_prod;
  logic [17:0] yr_days;
  logic [15:0] doy_full;
  logic [16:0] yb_sum;
  logic [19:0] n3;
  logic [31:0] day_prod;

  always_comb begin
    cent_prod = 40'({doc4, 2'b11}) * 40'(dcc_pkg::CenturyMul);
    yr_days   = 18'(dcc_pkg::DaysPer4Y) * 18'(yoc5);
    doy_full  = doc5 - yr_days[17:2];
    yb_sum    = 17'(q5) * 17'd100 + 17'(yoc5) - dcc_pkg::YearBias;
    n3        = 20'(doy6) * 20'(dcc_pkg::MonthMul) + dcc_pkg::MonthAdd;
    day_prod  = 32'(lo7) * 32'(dcc_pkg::DayRecip);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], v4};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 5
      q5   <= q4;
      doc5 <= doc4;
      yoc5 <= cent_prod[32 +: dcc_pkg::YocW];
      // stage 6
      doy6 <= doy_full[dcc_pkg::DoyW-1:0];
      yb6  <= yb_sum;
      // stage 7
      mon7  <= n3[19:16];
      lo7   <= n3[15:0];
      mar7  <= (doy6 >= dcc_pkg::MarchDays);
      year7 <= yb6[dcc_pkg::YearW-1:0];
      // stage 8
      day_of_month <= 5'(day_prod[dcc_pkg::DayShift +: dcc_pkg::DomW] + 5'd1);
      if (mar7) begin
        year  <= year7 + 16'd1;
        month <= mon7 - dcc_pkg::Months;
      end else begin
        year  <= year7;
        month <= mon7;
      end
    end
  end

  assign m_tvalid = vld[3];
  assign m_tdata  = {7'd0, day_of_month, month, year};

endmodule

FILE: rtl/core/dcc_era_div.sv
// Four-stage divider of the offset day count by the 400-year cycle length.
// Depends on dcc_pkg.
module dcc_era_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [dcc_pkg::DayW-1:0]  day_number,
  output logic                      out_valid,
  output logic [dcc_pkg::QW-1:0]    era_q,
  output logic [dcc_pkg::DocW-1:0]  doc
);

  logic [3:0] vld;

  logic [dcc_pkg::XW-1:0] x1, x2;
  logic [dcc_pkg::QW-1:0] q2, q3;
  logic [dcc_pkg::RW-1:0] r3;

  logic [27:0]            x_sum;
  logic [44:0]            est_prod;
  logic [26:0]            back_prod;
  logic [dcc_pkg::RW-1:0] r_fix;

  always_comb begin
    x_sum     = {{2{day_number[dcc_pkg::DayW-1]}}, day_number, 2'b00} + dcc_pkg::XOffset;
    est_prod  = 45'(x1) * 45'(dcc_pkg::EraRecip);
    back_prod = 27'(q2) * 27'(dcc_pkg::EraDiv);
    r_fix     = r3 - 19'(dcc_pkg::EraDiv);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1 <= x_sum[dcc_pkg::XW-1:0];
      x2 <= x1;
      q2 <= est_prod[dcc_pkg::EraShift +: dcc_pkg::QW];
      q3 <= q2;
      r3 <= 19'(x2 - back_prod);
      if (r3 >= 19'(dcc_pkg::EraDiv)) begin
        era_q <= q3 + 9'd1;
        doc   <= r_fix[17:2];
      end else begin
        era_q <= q3;
        doc   <= r3[17:2];
      end
    end
  end

  assign out_valid = vld[3];

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for day_count_to_civil_date: a scoreboard class predicts
// year/month/day per accepted day count; a task drives s_*, an initial block m_tready.
// Depends on dcc_pkg and the day_count_to_civil_date RTL.
module tb_top;

  // ---------------------------------------------------------------------
  // Calendar arithmetic constants (Euclidean affine form, shifted epoch)
  // ---------------------------------------------------------------------
  localparam longint unsigned EpochShift   = 64'd536895458; // epoch of shifted calendar
  localparam longint unsigned YearsRemoved = 64'd1468000;   // 400 * 3670 years
  localparam longint unsigned DaysPer400Y  = 64'd146097;
  localparam longint unsigned CenturyScale = 64'd2939745;
  localparam longint unsigned MonthScale   = 64'd2141;
  localparam longint unsigned MonthBias    = 64'd197913;
  localparam longint unsigned MarToDec     = 64'd306;       // days March..December
  localparam longint unsigned YearMonths   = 64'd12;

  localparam int DaysPerCentury = 36524;
  localparam int Mar1st2000     = 11017;  // 2000-03-01, a 400-year boundary
  localparam int MaxIdle        = 17;
  localparam int RandomDays     = 1450;
  localparam int PipeDepth      = 8;      // DUT pipeline depth, input beat to output beat

  typedef struct {
    logic [dcc_pkg::YearW-1:0]  year;
    logic [dcc_pkg::MonthW-1:0] month;
    logic [dcc_pkg::DomW-1:0]   dom;
  } civil_date_t;

  // ---------------------------------------------------------------------
  // Scoreboard: predicted dates in acceptance order, checked in order
  // ---------------------------------------------------------------------
  class civil_date_board;
    civil_date_t pending_dates[$];
    int unsigned mismatches;
    int unsigned days_noted;
    int unsigned dates_checked;

    // Day count -> proleptic Gregorian date. Year counted from March so the
    // leap day falls at the end; Jan/Feb fold back into the next year.
    function civil_date_t civil_date_of(input logic [dcc_pkg::DayW-1:0] day_count);
      longint          days;
      longint unsigned shifted, n1, centuries, day_of_cent, n2, u2;
      longint unsigned yr_of_cent, day_of_yr, n3, mon, dy, yr, yr_signed;
      civil_date_t     d;
      days        = longint'(signed'(day_count));
      shifted     = days + EpochShift;
      n1          = 4 * shifted + 3;
      centuries   = n1 / DaysPer400Y;
      day_of_cent = (n1 % DaysPer400Y) / 4;
      n2          = 4 * day_of_cent + 3;
      u2          = CenturyScale * n2;
      yr_of_cent  = u2 >> 32;
      day_of_yr   = (u2 & 64'hFFFF_FFFF) / CenturyScale / 4;
      n3          = MonthScale * day_of_yr + MonthBias;
      mon         = n3 >> 16;
      dy          = (n3 & 64'hFFFF) / MonthScale;
      yr          = 100 * centuries + yr_of_cent;
      if (day_of_yr >= MarToDec) begin
        yr  = yr + 1;
        mon = mon - YearMonths;
      end
      yr_signed = yr - YearsRemoved;
      d.year    = yr_signed[dcc_pkg::YearW-1:0];
      d.month   = mon[dcc_pkg::MonthW-1:0];
      d.dom     = dy[dcc_pkg::DomW-1:0] + 1'b1;
      return d;
    endfunction

    function void note_day(input logic [dcc_pkg::DayW-1:0] day_count);
      pending_dates.push_back(civil_date_of(day_count));
      days_noted++;
    endfunction

    // m_tdata: [15:0] year, [19:16] month, [24:20] day_of_month, [31:25] zero
    function void check_date(input logic [31:0] beat);
      civil_date_t want;
      if (pending_dates.size() == 0) begin
        $error("date beat %h arrived with no day count outstanding", beat);
        mismatches++;
        return;
      end
      want = pending_dates.pop_front();
      dates_checked++;
      if (beat[15:0] !== want.year) begin
        $error("year: expected %0d, got %0d", $signed(want.year), $signed(beat[15:0]));
        mismatches++;
      end
      if (beat[19:16] !== want.month) begin
        $error("month: expected %0d, got %0d", want.month, beat[19:16]);
        mismatches++;
      end
      if (beat[24:20] !== want.dom) begin
        $error("day_of_month: expected %0d, got %0d", want.dom, beat[24:20]);
        mismatches++;
      end
      if (beat[31:25] !== 7'd0) begin
        $error("pad: expected 0, got %h", beat[31:25]);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return pending_dates.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------
  // Clock, reset, DUT
  // ---------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;     // [23:0] day_number (signed)
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;          // [15:0] year, [19:16] month, [24:20] day_of_month

  civil_date_board board = new;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  day_count_to_civil_date dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Idle draw per beat; "steady" windows give back-to-back stretches
  function automatic int unsigned idle_cycles(input bit steady);
    return steady ? 0 : $urandom_range(0, MaxIdle);
  endfunction

  // Drive one day count; called and returning at a falling edge.
  // tvalid is only lowered when a gap is drawn, never dropped and re-raised
  // in the same step.
  task automatic send_day(input logic [dcc_pkg::DayW-1:0] day_count,
                          input int unsigned gap);
    repeat (gap) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= day_count;
    do @(posedge clk); while (!s_tready);
    board.note_day(day_count);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Result side: random back-pressure, with its own steady windows so the
  // stalls drift against the source gaps and hit every pipeline phase
  // ---------------------------------------------------------------------
  initial begin : date_sink
    int unsigned beats;
    beats = 0;
    do @(negedge clk); while (rst);
    forever begin
      repeat (idle_cycles(beats % 170 < 30)) begin
        m_tready <= 1'b0;
        @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      board.check_date(m_tdata);
      beats++;
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus: directed edges, then mixed random day counts
  // ---------------------------------------------------------------------
  initial begin : day_source
    int                       directed_days[$];
    int                       offs;
    int                       raw;
    int unsigned              pick;
    logic [dcc_pkg::DayW-1:0] day_count;

    // extremes, epoch, leap days (2000 leap, 1900 not, year 0 leap),
    // year and month rollovers, alternating bit patterns
    directed_days = '{-8388608, 8388607, 8388606, -8388607, 0, -1, 1,
                      58, 59, 364, 365, 10957, 11016, 11017, -25509, -25508,
                      -719469, -719468, 19723, 47482, 32'h555555, 32'hAAAAAA,
                      32'h0F0F0F, 32'hF0F0F0};

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_days[i]) begin
      raw = directed_days[i];
      send_day(raw[dcc_pkg::DayW-1:0], 0);
    end

    for (int i = 0; i < RandomDays; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        raw = $urandom();                        // anywhere in the 24-bit range
      end else if (pick < 7) begin
        raw = int'($urandom_range(0, 100000)) - 40000;  // around the epoch
      end else if (pick < 9) begin
        // close to a century boundary
        offs = int'($urandom_range(0, 458)) - 229;
        raw  = Mar1st2000 + offs * DaysPerCentury + int'($urandom_range(0, 1600)) - 800;
      end else begin
        // close to a 400-year boundary
        offs = int'($urandom_range(0, 114)) - 57;
        raw  = Mar1st2000 + offs * int'(DaysPer400Y) + int'($urandom_range(0, 1600)) - 800;
      end
      day_count = raw[dcc_pkg::DayW-1:0];
      send_day(day_count, idle_cycles(i % 200 < 40));
    end
    s_tvalid <= 1'b0;

    while (board.pending() != 0) @(negedge clk);
    repeat (3 * PipeDepth) @(negedge clk);

    $display("Converted %0d day counts and checked %0d dates", board.days_noted,
             board.dates_checked);
    $display("Covered: 24-bit extremes, leap/rollover edges, century and 400-year edges,");
    $display("         random gaps and back-pressure");
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: stops a run that hangs
  initial begin : watchdog
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/dcc_pkg.sv
rtl/core/dcc_era_div.sv
rtl/core/day_count_to_civil_date.sv
sim/tb_top.sv
